/* rtl/abvu_pkg.sv */
`default_nettype none

package abvu_pkg;

    localparam int GRID_POINTS = 4096;
    localparam int FRAC_BITS   = 16;
    localparam int IDX_W       = $clog2(GRID_POINTS);
    localparam int COEF_W      = FRAC_BITS + 2;
    localparam int CFG_AW      = 3;

    localparam longint Q_ONE = longint'(1) << FRAC_BITS;

    localparam logic [COEF_W-1:0] K_3_2   = COEF_W'((3 * Q_ONE + 1) / 2);
    localparam logic [COEF_W-1:0] K_1_2   = COEF_W'((Q_ONE + 1) / 2);
    localparam logic [COEF_W-1:0] K_23_12 = COEF_W'((23 * Q_ONE + 6) / 12);
    localparam logic [COEF_W-1:0] K_4_3   = COEF_W'((4 * Q_ONE + 1) / 3);
    localparam logic [COEF_W-1:0] K_5_12  = COEF_W'((5 * Q_ONE + 6) / 12);

    localparam logic [1:0] PH_EULER = 2'd0;
    localparam logic [1:0] PH_AB2   = 2'd1;
    localparam logic [1:0] PH_AB3   = 2'd2;

    localparam logic CFG_VISC  = 1'b0;
    localparam logic CFG_TSTEP = 1'b1;

    localparam logic [30:0] VISC_RESET  = 31'd66;
    localparam logic [30:0] TSTEP_RESET = 31'd66;

    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    typedef struct packed {
        logic        [11:0] point_index;
        logic        [1:0]  step_phase;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vx_dx;
        logic signed [31:0] vx_dy;
        logic signed [31:0] vy_dx;
        logic signed [31:0] vy_dy;
        logic signed [31:0] vx_lap;
        logic signed [31:0] vy_lap;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
    } pt_beat_t;

    typedef struct packed {
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic               saturated;
    } upd_beat_t;

    typedef struct packed {
        logic [30:0] viscosity;
        logic [30:0] step_size;
    } cfg_t;

    typedef struct packed {
        logic               valid;
        logic [IDX_W-1:0]   idx;
        logic signed [31:0] last_x;
        logic signed [31:0] last_y;
        logic               wr_before;
        logic signed [31:0] before_x;
        logic signed [31:0] before_y;
    } hist_wr_t;

    typedef struct packed {
        logic signed [31:0] last_x;
        logic signed [31:0] last_y;
        logic signed [31:0] before_x;
        logic signed [31:0] before_y;
    } hist_rd_t;

    typedef struct packed {
        logic               sat;
        logic signed [31:0] val;
    } sat_t;

    function automatic sat_t sat32(input logic signed [63:0] v);
        sat_t r;
        if (v > S32_MAX)
        begin
            r.sat = 1'b1;
            r.val = 32'sh7FFFFFFF;
        end
        else if (v < S32_MIN)
        begin
            r.sat = 1'b1;
            r.val = 32'sh80000000;
        end
        else
        begin
            r.sat = 1'b0;
            r.val = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/abvu_if.sv */
`default_nettype none

interface abvu_pt_if;
    import abvu_pkg::*;

    logic     valid;
    logic     ready;
    pt_beat_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface abvu_upd_if;
    import abvu_pkg::*;

    logic      valid;
    logic      ready;
    upd_beat_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/abvu_ram.sv */
`default_nettype none

module abvu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read-first on a same-address collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/abvu_cfg.sv */
`default_nettype none

module abvu_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [abvu_pkg::CFG_AW-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output      logic [31:0]                   prdata,
    output      logic                          pready,
    output      abvu_pkg::cfg_t                cfg
);
    import abvu_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                CFG_VISC:  cfg_next.viscosity = pwdata[30:0];
                CFG_TSTEP: cfg_next.step_size = pwdata[30:0];
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.viscosity <= VISC_RESET;
            cfg_reg.step_size <= TSTEP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            CFG_VISC:  prdata = {1'b0, cfg_reg.viscosity};
            CFG_TSTEP: prdata = {1'b0, cfg_reg.step_size};
            default:   prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* rtl/abvu_hist.sv */
`default_nettype none

module abvu_hist (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        advance,
    input  wire logic                        rd_en,
    input  wire logic [abvu_pkg::IDX_W-1:0]  rd_idx,
    input  wire abvu_pkg::hist_wr_t          wr,
    output      abvu_pkg::hist_rd_t          rd
);
    import abvu_pkg::*;

    logic [IDX_W-1:0] rd_idx_reg;
    hist_wr_t         old_wr_reg;
    logic [63:0]      last_q;
    logic [63:0]      before_q;
    logic             we_last;
    logic             we_before;
    logic             hit_new;
    logic             hit_old;

    assign we_last   = wr.valid && advance;
    assign we_before = wr.valid && wr.wr_before && advance;

    abvu_ram #(.WIDTH(64), .DEPTH(GRID_POINTS)) u_last (
        .clk   (clk),
        .we    (we_last),
        .waddr (wr.idx),
        .wdata ({wr.last_y, wr.last_x}),
        .re    (rd_en),
        .raddr (rd_idx),
        .rdata (last_q)
    );

    abvu_ram #(.WIDTH(64), .DEPTH(GRID_POINTS)) u_before (
        .clk   (clk),
        .we    (we_before),
        .waddr (wr.idx),
        .wdata ({wr.before_y, wr.before_x}),
        .re    (rd_en),
        .raddr (rd_idx),
        .rdata (before_q)
    );

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_idx_reg <= rd_idx;
        end
    end

    // the write that landed on the same edge as the read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            old_wr_reg <= '0;
        end
        else if (advance)
        begin
            old_wr_reg <= wr;
        end
    end

    assign hit_new = wr.valid && (wr.idx == rd_idx_reg);
    assign hit_old = old_wr_reg.valid && (old_wr_reg.idx == rd_idx_reg);

    always_comb
    begin
        priority if (hit_new)
        begin
            rd.last_x = wr.last_x;
            rd.last_y = wr.last_y;
        end
        else if (hit_old)
        begin
            rd.last_x = old_wr_reg.last_x;
            rd.last_y = old_wr_reg.last_y;
        end
        else
        begin
            rd.last_x = last_q[31:0];
            rd.last_y = last_q[63:32];
        end

        priority if (hit_new && wr.wr_before)
        begin
            rd.before_x = wr.before_x;
            rd.before_y = wr.before_y;
        end
        else if (hit_old && old_wr_reg.wr_before)
        begin
            rd.before_x = old_wr_reg.before_x;
            rd.before_y = old_wr_reg.before_y;
        end
        else
        begin
            rd.before_x = before_q[31:0];
            rd.before_y = before_q[63:32];
        end
    end

endmodule

`default_nettype wire

/* rtl/adams_bashforth_velocity_update.sv */
// Adams-Bashforth velocity update, one grid point per beat.
// point: one beat carries a grid point's velocity, first derivatives,
//   Laplacians, force, history index and step phase (valid/ready).
// update: one beat per point, new velocity and a saturation flag, in order.
// APB port: viscosity at 0x0, step size at 0x4; write only while idle.
// Throughput: one point per cycle while point.ready is high, set by the single
//   read and write port of each history RAM; the read-modify-write forwards
//   from the two writes still in flight, so any index order runs at full rate.
// Pipeline: six register stages (a, b, c, d, e and the output register), the
//   first loaded at the accept edge; the update beat is offered from the last.
// History: two 4096 x 64 RAMs (newest and previous right-hand side, x and
//   y packed); contents are undefined until a phase writes them.
// Reset: pipeline and output empty, registers back to 66; RAMs untouched.
// Stall: while update is held off, the pipeline keeps moving as long as
//   the stage before the output register is empty; point.ready drops only
//   when that stage and the output register are both full.
`default_nettype none

module adams_bashforth_velocity_update (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [abvu_pkg::CFG_AW-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output      logic [31:0]                  prdata,
    output      logic                         pready,
    abvu_pt_if.sink                           point,
    abvu_upd_if.source                        update
);
    import abvu_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic [1:0]         phase;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [63:0] pax;
        logic signed [63:0] pay;
        logic signed [63:0] pvx;
        logic signed [63:0] pbx;
        logic signed [63:0] pby;
        logic signed [63:0] pvy;
    } a_t;

    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic [1:0]         phase;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] rhs_x;
        logic signed [31:0] rhs_y;
        logic signed [31:0] r1_x;
        logic signed [31:0] r1_y;
        logic signed [31:0] r0_x;
        logic signed [31:0] r0_y;
        logic               sat;
    } b_t;

    typedef struct packed {
        logic [1:0]         phase;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] rhs_x;
        logic signed [31:0] rhs_y;
        logic signed [63:0] m0x;
        logic signed [63:0] m1x;
        logic signed [63:0] m2x;
        logic signed [63:0] m0y;
        logic signed [63:0] m1y;
        logic signed [63:0] m2y;
        logic               sat;
    } c_t;

    typedef struct packed {
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] inc_x;
        logic signed [31:0] inc_y;
        logic               sat;
    } d_t;

    typedef struct packed {
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [63:0] tpx;
        logic signed [63:0] tpy;
        logic               sat;
    } e_t;

    cfg_t      cfg;
    hist_wr_t  hwr;
    hist_rd_t  hrd;

    a_t        a_reg, a_next;
    b_t        b_reg, b_next;
    c_t        c_reg, c_next;
    d_t        d_reg, d_next;
    e_t        e_reg, e_next;
    upd_beat_t out_reg, out_next;

    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg, e_valid_reg;
    logic out_valid_reg, out_valid_next;

    logic adv;
    logic accept;

    logic signed [31:0]       visc_s;
    logic signed [31:0]       tstep_s;
    logic [COEF_W-1:0]        k0, k1, k2;
    logic signed [COEF_W:0]   k0_s, k1_s, k2_s;
    sat_t rhs_sx, rhs_sy, inc_sx, inc_sy, vel_sx, vel_sy;

    abvu_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign adv    = !e_valid_reg || !out_valid_reg || update.ready;
    assign accept = point.valid && adv;

    assign point.ready    = adv;
    assign update.valid   = out_valid_reg;
    assign update.payload = out_reg;

    abvu_hist u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (adv),
        .rd_en   (accept),
        .rd_idx  (a_next.idx),
        .wr      (hwr),
        .rd      (hrd)
    );

    assign visc_s  = $signed({1'b0, cfg.viscosity});
    assign tstep_s = $signed({1'b0, cfg.step_size});

    // products of the right-hand side
    always_comb
    begin
        a_next.idx = IDX_W'(point.payload.point_index);
        if (point.payload.step_phase == PH_EULER)
        begin
            a_next.phase = PH_EULER;
        end
        else if (point.payload.step_phase == PH_AB2)
        begin
            a_next.phase = PH_AB2;
        end
        else
        begin
            a_next.phase = PH_AB3;
        end
        a_next.vel_x   = point.payload.vel_x;
        a_next.vel_y   = point.payload.vel_y;
        a_next.force_x = point.payload.force_x;
        a_next.force_y = point.payload.force_y;
        a_next.pax = $signed(point.payload.vel_x) * $signed(point.payload.vx_dx);
        a_next.pay = $signed(point.payload.vel_y) * $signed(point.payload.vx_dy);
        a_next.pvx = visc_s * $signed(point.payload.vx_lap);
        a_next.pbx = $signed(point.payload.vel_x) * $signed(point.payload.vy_dx);
        a_next.pby = $signed(point.payload.vel_y) * $signed(point.payload.vy_dy);
        a_next.pvy = visc_s * $signed(point.payload.vy_lap);
    end

    // right-hand side, history read
    always_comb
    begin
        rhs_sx = sat32(-(a_reg.pax >>> FRAC_BITS) - (a_reg.pay >>> FRAC_BITS)
                       + (a_reg.pvx >>> FRAC_BITS) + 64'(a_reg.force_x));
        rhs_sy = sat32(-(a_reg.pbx >>> FRAC_BITS) - (a_reg.pby >>> FRAC_BITS)
                       + (a_reg.pvy >>> FRAC_BITS) + 64'(a_reg.force_y));
        b_next.idx   = a_reg.idx;
        b_next.phase = a_reg.phase;
        b_next.vel_x = a_reg.vel_x;
        b_next.vel_y = a_reg.vel_y;
        b_next.rhs_x = rhs_sx.val;
        b_next.rhs_y = rhs_sy.val;
        b_next.r1_x  = hrd.last_x;
        b_next.r1_y  = hrd.last_y;
        b_next.r0_x  = hrd.before_x;
        b_next.r0_y  = hrd.before_y;
        b_next.sat   = rhs_sx.sat || rhs_sy.sat;
    end

    always_comb
    begin
        hwr.valid     = b_valid_reg;
        hwr.idx       = b_reg.idx;
        hwr.last_x    = b_reg.rhs_x;
        hwr.last_y    = b_reg.rhs_y;
        hwr.wr_before = (b_reg.phase != PH_EULER);
        hwr.before_x  = b_reg.r1_x;
        hwr.before_y  = b_reg.r1_y;
    end

    // weighted history products
    always_comb
    begin
        unique case (b_reg.phase)
            PH_EULER:
            begin
                k0 = '0;
                k1 = '0;
                k2 = '0;
            end
            PH_AB2:
            begin
                k0 = K_3_2;
                k1 = K_1_2;
                k2 = '0;
            end
            default:
            begin
                k0 = K_23_12;
                k1 = K_4_3;
                k2 = K_5_12;
            end
        endcase
        k0_s = $signed({1'b0, k0});
        k1_s = $signed({1'b0, k1});
        k2_s = $signed({1'b0, k2});
        c_next.phase = b_reg.phase;
        c_next.vel_x = b_reg.vel_x;
        c_next.vel_y = b_reg.vel_y;
        c_next.rhs_x = b_reg.rhs_x;
        c_next.rhs_y = b_reg.rhs_y;
        c_next.m0x   = k0_s * b_reg.rhs_x;
        c_next.m1x   = k1_s * b_reg.r1_x;
        // the older entry may be unwritten below third order
        c_next.m2x   = (b_reg.phase == PH_AB3) ? k2_s * b_reg.r0_x : 64'sd0;
        c_next.m0y   = k0_s * b_reg.rhs_y;
        c_next.m1y   = k1_s * b_reg.r1_y;
        c_next.m2y   = (b_reg.phase == PH_AB3) ? k2_s * b_reg.r0_y : 64'sd0;
        c_next.sat   = b_reg.sat;
    end

    always_comb
    begin
        inc_sx = sat32((c_reg.m0x - c_reg.m1x + c_reg.m2x) >>> FRAC_BITS);
        inc_sy = sat32((c_reg.m0y - c_reg.m1y + c_reg.m2y) >>> FRAC_BITS);
        d_next.vel_x = c_reg.vel_x;
        d_next.vel_y = c_reg.vel_y;
        if (c_reg.phase == PH_EULER)
        begin
            d_next.inc_x = c_reg.rhs_x;
            d_next.inc_y = c_reg.rhs_y;
            d_next.sat   = c_reg.sat;
        end
        else
        begin
            d_next.inc_x = inc_sx.val;
            d_next.inc_y = inc_sy.val;
            d_next.sat   = c_reg.sat || inc_sx.sat || inc_sy.sat;
        end
    end

    always_comb
    begin
        e_next.vel_x = d_reg.vel_x;
        e_next.vel_y = d_reg.vel_y;
        e_next.tpx   = tstep_s * d_reg.inc_x;
        e_next.tpy   = tstep_s * d_reg.inc_y;
        e_next.sat   = d_reg.sat;
    end

    always_comb
    begin
        vel_sx = sat32(64'(e_reg.vel_x) + (e_reg.tpx >>> FRAC_BITS));
        vel_sy = sat32(64'(e_reg.vel_y) + (e_reg.tpy >>> FRAC_BITS));
        out_next.new_vel_x = vel_sx.val;
        out_next.new_vel_y = vel_sy.val;
        out_next.saturated = e_reg.sat || vel_sx.sat || vel_sy.sat;
    end

    always_comb
    begin
        if (adv && e_valid_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (update.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
            d_reg <= d_next;
            e_reg <= e_next;
        end
        if (adv && e_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                a_valid_reg <= accept;
                b_valid_reg <= a_valid_reg;
                c_valid_reg <= b_valid_reg;
                d_valid_reg <= c_valid_reg;
                e_valid_reg <= d_valid_reg;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable({a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg,
                          e_valid_reg}))
        else $error("pipeline moved while stalled");

    a_beat_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (point.valid && point.ready) |=> a_valid_reg)
        else $error("accepted beat not in first stage");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(e_valid_reg))
        else $error("result appeared without a finished point");

    a_phase_norm: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg |-> (c_reg.phase == PH_EULER || c_reg.phase == PH_AB2 ||
                         c_reg.phase == PH_AB3))
        else $error("phase not normalized");

endmodule

`default_nettype wire

/* tb/abvu_checker.sv */
`timescale 1ns / 100ps

module abvu_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [abvu_pkg::CFG_AW-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    input  logic [31:0]                  prdata,
    input  logic                         pready,
    abvu_pt_if                           point,
    abvu_upd_if                          update,
    output int                           mismatches,
    output int                           pending,
    output int                           points_seen,
    output int                           updates_seen,
    output int                           saturated_seen
);
    import abvu_pkg::*;

    localparam longint Q1        = longint'(1) << FRAC_BITS;
    localparam longint W_AB2_NEW = (3 * Q1 + 1) / 2;
    localparam longint W_AB2_OLD = (Q1 + 1) / 2;
    localparam longint W_AB3_NEW = (23 * Q1 + 6) / 12;
    localparam longint W_AB3_MID = (4 * Q1 + 1) / 3;
    localparam longint W_AB3_OLD = (5 * Q1 + 6) / 12;

    logic [30:0] visc_q  = VISC_RESET;
    logic [30:0] tstep_q = TSTEP_RESET;

    longint rhs_x_latest [GRID_POINTS];
    longint rhs_x_prior  [GRID_POINTS];
    longint rhs_y_latest [GRID_POINTS];
    longint rhs_y_prior  [GRID_POINTS];

    upd_beat_t expected_updates [$];

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at %0t: %s", $time, what);
    endtask

    function automatic longint qfloor(input longint v);
        return v >>> FRAC_BITS;
    endfunction

    function automatic longint clamp32(input longint v, inout bit clipped);
        if (v > S32_MAX)
        begin
            clipped = 1'b1;
            return S32_MAX;
        end
        if (v < S32_MIN)
        begin
            clipped = 1'b1;
            return S32_MIN;
        end
        return v;
    endfunction

    // one velocity component; rotates that component's history
    function automatic longint advance_comp(
        input longint     vel,
        input longint     ux,
        input longint     uy,
        input longint     dx,
        input longint     dy,
        input longint     lap,
        input longint     frc,
        input logic [1:0] ph,
        inout longint     latest,
        inout longint     prior,
        inout bit         clipped
    );
        longint adv;
        longint visc_term;
        longint rhs;
        longint incr;
        adv       = qfloor(ux * dx) + qfloor(uy * dy);
        visc_term = qfloor(longint'(visc_q) * lap);
        rhs       = clamp32(visc_term - adv + frc, clipped);
        case (ph)
            PH_EULER: incr = rhs;
            PH_AB2:   incr = clamp32(qfloor(W_AB2_NEW * rhs - W_AB2_OLD * latest), clipped);
            default:  incr = clamp32(qfloor(W_AB3_NEW * rhs - W_AB3_MID * latest
                                            + W_AB3_OLD * prior), clipped);
        endcase
        if (ph != PH_EULER)
            prior = latest;
        latest = rhs;
        return clamp32(vel + qfloor(longint'(tstep_q) * incr), clipped);
    endfunction

    function automatic upd_beat_t predict_update(input pt_beat_t b);
        upd_beat_t   r;
        bit          clipped;
        longint      lx;
        longint      px;
        longint      ly;
        longint      py;
        longint      nx;
        longint      ny;
        int unsigned a;
        a       = b.point_index % GRID_POINTS;
        clipped = 1'b0;
        lx      = rhs_x_latest[a];
        px      = rhs_x_prior[a];
        ly      = rhs_y_latest[a];
        py      = rhs_y_prior[a];
        nx = advance_comp($signed(b.vel_x), $signed(b.vel_x), $signed(b.vel_y),
                          $signed(b.vx_dx), $signed(b.vx_dy), $signed(b.vx_lap),
                          $signed(b.force_x), b.step_phase, lx, px, clipped);
        ny = advance_comp($signed(b.vel_y), $signed(b.vel_x), $signed(b.vel_y),
                          $signed(b.vy_dx), $signed(b.vy_dy), $signed(b.vy_lap),
                          $signed(b.force_y), b.step_phase, ly, py, clipped);
        rhs_x_latest[a] = lx;
        rhs_x_prior[a]  = px;
        rhs_y_latest[a] = ly;
        rhs_y_prior[a]  = py;
        r.new_vel_x = nx[31:0];
        r.new_vel_y = ny[31:0];
        r.saturated = clipped;
        return r;
    endfunction

    always @(posedge clk)
    begin
        upd_beat_t want;
        if (rst_n)
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (paddr[CFG_AW-1:2])
                        CFG_VISC:  visc_q  = pwdata[30:0];
                        CFG_TSTEP: tstep_q = pwdata[30:0];
                        default: ;
                    endcase
                end
                else
                begin
                    case (paddr[CFG_AW-1:2])
                        CFG_VISC:
                            if (prdata !== {1'b0, visc_q})
                                flag_mismatch($sformatf("viscosity read %0h, expected %0h",
                                                        prdata, visc_q));
                        CFG_TSTEP:
                            if (prdata !== {1'b0, tstep_q})
                                flag_mismatch($sformatf("step size read %0h, expected %0h",
                                                        prdata, tstep_q));
                        default: ;
                    endcase
                end
            end

            if (update.valid && update.ready)
            begin
                updates_seen++;
                if (expected_updates.size() == 0)
                    flag_mismatch($sformatf("update beat %0d with nothing expected",
                                            updates_seen));
                else
                begin
                    want = expected_updates.pop_front();
                    if (update.payload.new_vel_x !== want.new_vel_x)
                        flag_mismatch($sformatf("update %0d new_vel_x %0d, expected %0d",
                                                updates_seen, update.payload.new_vel_x,
                                                want.new_vel_x));
                    if (update.payload.new_vel_y !== want.new_vel_y)
                        flag_mismatch($sformatf("update %0d new_vel_y %0d, expected %0d",
                                                updates_seen, update.payload.new_vel_y,
                                                want.new_vel_y));
                    if (update.payload.saturated !== want.saturated)
                        flag_mismatch($sformatf("update %0d saturated %b, expected %b",
                                                updates_seen, update.payload.saturated,
                                                want.saturated));
                end
            end

            if (point.valid && point.ready)
            begin
                points_seen++;
                want = predict_update(point.payload);
                if (want.saturated)
                    saturated_seen++;
                expected_updates.push_back(want);
            end

            pending = expected_updates.size();
        end
    end

endmodule

/* tb/adams_bashforth_velocity_update_tb.sv */
`timescale 1ns / 100ps

module adams_bashforth_velocity_update_tb;
    import abvu_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 150;
    localparam int SETTLE_CYCLES = 8;
    localparam int SEG_POINTS    = 300;

    localparam logic [1:0]        PH_AB3_ALIAS = 2'd3;
    localparam logic [CFG_AW-1:0] ADDR_VISC    = {CFG_VISC, 2'b00};
    localparam logic [CFG_AW-1:0] ADDR_TSTEP   = {CFG_TSTEP, 2'b00};

    typedef enum int {FILL_ZERO, FILL_MAX, FILL_MIN, FILL_NEG1, FILL_RAND} fill_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    abvu_pt_if  pt_ch ();
    abvu_upd_if upd_ch ();

    int               gap_pct;
    int               stall_pct;
    bit               hold_req;
    int               cycle_count;
    int               reg_writes;
    bit               has_last  [GRID_POINTS];
    bit               has_prior [GRID_POINTS];
    logic [IDX_W-1:0] pool_base;

    int mismatch_count;
    int pending_count;
    int points_seen;
    int updates_seen;
    int saturated_seen;

    adams_bashforth_velocity_update dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .point   (pt_ch),
        .update  (upd_ch)
    );

    abvu_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .point          (pt_ch),
        .update         (upd_ch),
        .mismatches     (mismatch_count),
        .pending        (pending_count),
        .points_seen    (points_seen),
        .updates_seen   (updates_seen),
        .saturated_seen (saturated_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #10 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[adams_bashforth_velocity_update] ERROR");
        $finish;
    end

    // output side; a hold request stalls it for a long stretch
    initial
    begin
        upd_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                upd_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            upd_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic signed [31:0] rand_q();
        int unsigned r;
        r = $urandom_range(9);
        if (r < 3)
            return $urandom;
        if (r == 3)
            return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        // roughly +-4.0
        return $signed($urandom_range(32'h7FFFF)) - 32'sh40000;
    endfunction

    function automatic logic signed [31:0] fill_word(input fill_t f);
        case (f)
            FILL_ZERO: return 32'sd0;
            FILL_MAX:  return 32'sh7FFF_FFFF;
            FILL_MIN:  return 32'sh8000_0000;
            FILL_NEG1: return -32'sd1;
            default:   return rand_q();
        endcase
    endfunction

    function automatic pt_beat_t make_point(input logic [IDX_W-1:0] idx, input logic [1:0] ph,
                                            input fill_t f);
        pt_beat_t b;
        b.point_index = idx;
        b.step_phase  = ph;
        b.vel_x       = fill_word(f);
        b.vel_y       = fill_word(f);
        b.vx_dx       = fill_word(f);
        b.vx_dy       = fill_word(f);
        b.vy_dx       = fill_word(f);
        b.vy_dy       = fill_word(f);
        b.vx_lap      = fill_word(f);
        b.vy_lap      = fill_word(f);
        b.force_x     = fill_word(f);
        b.force_y     = fill_word(f);
        return b;
    endfunction

    // mostly a small working set so points run through all three phases
    function automatic pt_beat_t next_point();
        logic [IDX_W-1:0] idx;
        logic [1:0]       ph;
        int unsigned      r;
        if ($urandom_range(99) < 80)
            idx = pool_base + IDX_W'($urandom_range(15));
        else
            idx = IDX_W'($urandom_range(GRID_POINTS - 1));
        r = $urandom_range(9);
        if (has_prior[idx])
            ph = (r < 6) ? PH_AB3 : (r < 7) ? PH_AB3_ALIAS : (r < 8) ? PH_AB2 : PH_EULER;
        else if (has_last[idx])
            ph = (r < 7) ? PH_AB2 : PH_EULER;
        else
            ph = PH_EULER;
        return make_point(idx, ph, FILL_RAND);
    endfunction

    task automatic push_point(input pt_beat_t b);
        int gap;
        gap = 0;
        while ($urandom_range(99) < gap_pct && gap < 40)
            gap++;
        if (gap > 0)
        begin
            pt_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pt_ch.valid   <= 1'b1;
        pt_ch.payload <= b;
        @(posedge clk);
        while (!pt_ch.ready)
            @(posedge clk);
        has_last[b.point_index] = 1'b1;
        if (b.step_phase != PH_EULER)
            has_prior[b.point_index] = 1'b1;
    endtask

    task automatic drain_updates();
        pt_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [CFG_AW-1:0] addr,
                              input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_regs(input logic [31:0] visc, input logic [31:0] tstep);
        drain_updates();
        apb_access(1'b1, ADDR_VISC, visc);
        apb_access(1'b1, ADDR_TSTEP, tstep);
        apb_access(1'b0, ADDR_VISC, '0);
        apb_access(1'b0, ADDR_TSTEP, '0);
        reg_writes += 2;
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        pt_ch.valid   <= 1'b0;
        pt_ch.payload <= '0;
        gap_pct    = 0;
        stall_pct  = 0;
        hold_req   = 1'b0;
        reg_writes = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values
        apb_access(1'b0, ADDR_VISC, '0);
        apb_access(1'b0, ADDR_TSTEP, '0);

        push_point(make_point(12'd0, PH_EULER, FILL_ZERO));
        push_point(make_point(12'd4095, PH_EULER, FILL_MAX));
        push_point(make_point(12'd0, PH_AB2, FILL_MIN));
        push_point(make_point(12'd0, PH_AB3, FILL_MAX));
        push_point(make_point(12'd0, PH_AB3_ALIAS, FILL_NEG1));
        push_point(make_point(12'd4095, PH_AB2, FILL_MIN));
        push_point(make_point(12'd4095, PH_AB3_ALIAS, FILL_RAND));
        push_point(make_point(12'd4095, PH_AB3, FILL_NEG1));
        push_point(make_point(12'd2730, PH_EULER, FILL_NEG1));
        push_point(make_point(12'd1365, PH_EULER, FILL_RAND));
        push_point(make_point(12'd2730, PH_AB2, FILL_RAND));
        push_point(make_point(12'd1365, PH_AB2, FILL_MAX));
        push_point(make_point(12'd2730, PH_AB3, FILL_MIN));
        push_point(make_point(12'd1365, PH_AB3_ALIAS, FILL_ZERO));
        // same point back to back
        push_point(make_point(12'd7, PH_EULER, FILL_RAND));
        push_point(make_point(12'd7, PH_AB2, FILL_RAND));
        push_point(make_point(12'd7, PH_AB3, FILL_RAND));
        push_point(make_point(12'd7, PH_AB3, FILL_RAND));
        push_point(make_point(12'd7, PH_AB3_ALIAS, FILL_RAND));
        push_point(make_point(12'd7, PH_EULER, FILL_RAND));
        push_point(make_point(12'd7, PH_AB2, FILL_RAND));

        for (int seg = 0; seg < 6; seg++)
        begin
            case (seg)
                0:
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    set_regs(32'h0001_0000, 32'h0000_199A);
                    gap_pct   = 74;
                    stall_pct = 0;
                end
                2:
                begin
                    set_regs(32'h0000_0000, 32'h7FFF_FFFF);
                    gap_pct   = 0;
                    stall_pct = 74;
                end
                3:
                begin
                    set_regs(32'h7FFF_FFFF, 32'h0000_0000);
                    gap_pct   = 6;
                    stall_pct = 6;
                end
                4:
                begin
                    set_regs($urandom, $urandom);
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                default:
                begin
                    set_regs($urandom_range(32'h3FFFF) | 32'h8000_0000,
                             $urandom_range(32'h1FFFF));
                    gap_pct   = 6;
                    stall_pct = 6;
                end
            endcase
            pool_base = IDX_W'($urandom_range(GRID_POINTS - 1));
            for (int n = 0; n < SEG_POINTS; n++)
            begin
                if (seg == 0 && n == 100)
                    hold_req = 1'b1;
                push_point(next_point());
            end
        end

        drain_updates();
        repeat (20) @(posedge clk);

        $display("Run covered %0d point beats over six register settings (%0d writes),",
                 points_seen, reg_writes);
        $display("all step phases, a long output hold-off; %0d updates, %0d saturated.",
                 updates_seen, saturated_seen);
        if (mismatch_count == 0)
            $display("[adams_bashforth_velocity_update] OK");
        else
            $display("[adams_bashforth_velocity_update] ERROR");
        $finish;
    end

endmodule

/* filelist.f */
rtl/abvu_pkg.sv
rtl/abvu_if.sv
rtl/abvu_ram.sv
rtl/abvu_cfg.sv
rtl/abvu_hist.sv
rtl/adams_bashforth_velocity_update.sv
tb/abvu_checker.sv
tb/adams_bashforth_velocity_update_tb.sv
